### rtl/gmb_pkg.sv
package gmb_pkg;

  localparam int unsigned VERTEX_CAPACITY    = 65536;
  localparam int unsigned MESHLET_VERTEX_MAX = 64;

  localparam int unsigned VERTEX_W   = 16;
  localparam int unsigned REMAP_W    = 8;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 104;

  localparam logic [REMAP_W-1:0] UNASSIGNED = 8'hff;
  localparam logic [8:0]         INDEX_CAP  = 9'd384;
  localparam logic [8:0]         LIMIT_MIN  = 9'd3;

  localparam logic [6:0] VERTEX_LIMIT_RST = 7'd64;
  localparam logic [8:0] INDEX_LIMIT_RST  = 9'd378;

  localparam logic CFG_VERTEX_LIMIT = 1'b0;
  localparam logic CFG_INDEX_LIMIT  = 1'b1;

  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

endpackage

### rtl/gmb_ram.sv
module gmb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/gmb_slot_map.sv
module gmb_slot_map #(
  parameter int unsigned CAPACITY = gmb_pkg::VERTEX_CAPACITY,
  localparam int unsigned SLOT_W  = $clog2(CAPACITY)
) (
  input  logic [gmb_pkg::VERTEX_W-1:0] vertex_i,
  output logic [SLOT_W-1:0]            slot_o
);

  localparam logic [31:0] CAP = 32'(CAPACITY);

  logic [31:0] rem;

  // CAPACITY >= 256, so the quotient of a 16-bit index fits in 8 bits
  always_comb begin
    rem = 32'(vertex_i);
    for (int k = 7; k >= 0; k--) begin
      if (rem >= (CAP << k)) begin
        rem = rem - (CAP << k);
      end
    end
  end

  assign slot_o = rem[SLOT_W-1:0];

endmodule

### rtl/greedy_meshlet_builder_top.sv
// Greedy meshlet builder. Triangles (three global vertex indices) are packed into meshlets;
// one result per input transaction. After reset the remap memory is swept to "unassigned",
// one entry per cycle; s_axis_tready stays low until the sweep is done.
// One item is processed at a time: an add runs three remap reads, a limit check and three
// append steps on the single remap memory, plus the result load; closing a meshlet adds a
// walk of the vertex list that clears its remap entries. A finish goes straight to the result
// load, with the same walk first when it closes a non-empty meshlet. The result sits in an
// output register, so the next item may be accepted while it waits.
module greedy_meshlet_builder_top #(
  parameter int unsigned VERTEX_CAPACITY    = gmb_pkg::VERTEX_CAPACITY,
  parameter int unsigned MESHLET_VERTEX_MAX = gmb_pkg::MESHLET_VERTEX_MAX
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // vertex_a, vertex_b, vertex_c
  input  logic [gmb_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // action
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // closed vtx count, closed idx count, meshlet_number, local_a, local_b, local_c,
  // new vtx count, new_vertex_0, new_vertex_1, new_vertex_2, zero pad
  output logic [gmb_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // meshlet_closed
  output logic                               m_axis_tuser,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [gmb_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned RAW = $clog2(VERTEX_CAPACITY);
  localparam int unsigned LAW = $clog2(MESHLET_VERTEX_MAX);
  localparam int unsigned VCW = $clog2(MESHLET_VERTEX_MAX + 1);
  localparam int unsigned VW  = gmb_pkg::VERTEX_W;
  localparam int unsigned RW  = gmb_pkg::REMAP_W;

  localparam logic [RAW-1:0] CLR_LAST = RAW'(VERTEX_CAPACITY - 1);
  localparam logic [VCW-1:0] VC_MAX   = VCW'(MESHLET_VERTEX_MAX);
  localparam logic [7:0]     VLIM_MAX = 8'(MESHLET_VERTEX_MAX);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD_A, ST_RD_B, ST_RD_C, ST_CHECK, ST_WALK, ST_APPEND, ST_DONE
  } state_e;

  state_e         state_q, state_d;
  logic [RAW-1:0] clr_q, clr_d;
  logic           finish_q, finish_d;
  logic [VW-1:0]  corner_q [3];
  logic [VW-1:0]  corner_d [3];
  logic [RAW-1:0] pos_q [3];
  logic [RAW-1:0] pos_d [3];
  logic [RW-1:0]  rv_q [3];
  logic [RW-1:0]  rv_d [3];
  logic [RW-1:0]  fval_q [3];
  logic [RW-1:0]  fval_d [3];
  logic [1:0]     k_q, k_d;
  logic [VCW-1:0] vc_q, vc_d;
  logic [8:0]     ic_q, ic_d;
  logic [15:0]    mc_q, mc_d;
  logic [VCW-1:0] walk_q, walk_d;
  logic           pend_q, pend_d;
  logic           closed_q, closed_d;
  logic [6:0]     cvc_q, cvc_d;
  logic [8:0]     cic_q, cic_d;
  logic [5:0]     loc_q [3];
  logic [5:0]     loc_d [3];
  logic [1:0]     added_q, added_d;
  logic [VW-1:0]  newv_q [3];
  logic [VW-1:0]  newv_d [3];
  logic [6:0]     vlimit_q, vlimit_d;
  logic [8:0]     ilimit_q, ilimit_d;
  logic           m_valid_q, m_valid_d;
  logic [gmb_pkg::OUT_DATA_W-1:0] m_data_q, m_data_d;
  logic           m_user_q, m_user_d;

  logic           rm_we;
  logic [RAW-1:0] rm_waddr, rm_raddr;
  logic [RW-1:0]  rm_wdata, rm_rdata;
  logic           ls_we;
  logic [LAW-1:0] ls_waddr, ls_raddr;
  logic [VW-1:0]  ls_wdata, ls_rdata;
  logic [VW-1:0]  sm_in;
  logic [RAW-1:0] sm_slot;

  logic [7:0]     vlim;
  logic [8:0]     ilim;
  logic [1:0]     fresh;
  logic [8:0]     vc_need;
  logic [9:0]     ic_need;
  logic [RW-1:0]  eff;
  logic [7:0]     vc8;

  gmb_ram #(.WIDTH(RW), .DEPTH(VERTEX_CAPACITY)) u_remap (
    .clk_i  (clk_i),
    .we_i   (rm_we),
    .waddr_i(rm_waddr),
    .wdata_i(rm_wdata),
    .raddr_i(rm_raddr),
    .rdata_o(rm_rdata)
  );

  gmb_ram #(.WIDTH(VW), .DEPTH(MESHLET_VERTEX_MAX)) u_list (
    .clk_i  (clk_i),
    .we_i   (ls_we),
    .waddr_i(ls_waddr),
    .wdata_i(ls_wdata),
    .raddr_i(ls_raddr),
    .rdata_o(ls_rdata)
  );

  gmb_slot_map #(.CAPACITY(VERTEX_CAPACITY)) u_slot (
    .vertex_i(sm_in),
    .slot_o  (sm_slot)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // clamped limits
  always_comb begin
    vlim = {1'b0, vlimit_q};
    if (vlim < 8'(gmb_pkg::LIMIT_MIN)) begin
      vlim = 8'(gmb_pkg::LIMIT_MIN);
    end else if (vlim > VLIM_MAX) begin
      vlim = VLIM_MAX;
    end
    ilim = ilimit_q;
    if (ilim < gmb_pkg::LIMIT_MIN) begin
      ilim = gmb_pkg::LIMIT_MIN;
    end else if (ilim > gmb_pkg::INDEX_CAP) begin
      ilim = gmb_pkg::INDEX_CAP;
    end
  end

  assign fresh = 2'(rv_q[0] == gmb_pkg::UNASSIGNED) + 2'(rv_q[1] == gmb_pkg::UNASSIGNED)
               + 2'(rm_rdata == gmb_pkg::UNASSIGNED);
  assign vc8     = 8'(vc_q);
  assign vc_need = {1'b0, vc8} + 9'(fresh);
  assign ic_need = {1'b0, ic_q} + 10'd3;

  // remap value of the current corner, forwarded from earlier corners of the same triangle
  always_comb begin
    eff = rv_q[k_q];
    if (k_q != 2'd0 && pos_q[k_q] == pos_q[0]) begin
      eff = fval_q[0];
    end
    if (k_q == 2'd2 && pos_q[2] == pos_q[1]) begin
      eff = fval_q[1];
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    finish_d  = finish_q;
    corner_d  = corner_q;
    pos_d     = pos_q;
    rv_d      = rv_q;
    fval_d    = fval_q;
    k_d       = k_q;
    vc_d      = vc_q;
    ic_d      = ic_q;
    mc_d      = mc_q;
    walk_d    = walk_q;
    pend_d    = pend_q;
    closed_d  = closed_q;
    cvc_d     = cvc_q;
    cic_d     = cic_q;
    loc_d     = loc_q;
    added_d   = added_q;
    newv_d    = newv_q;
    vlimit_d  = vlimit_q;
    ilimit_d  = ilimit_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;

    rm_we    = 1'b0;
    rm_waddr = pos_q[k_q];
    rm_wdata = gmb_pkg::UNASSIGNED;
    rm_raddr = sm_slot;
    ls_we    = 1'b0;
    ls_waddr = vc_q[LAW-1:0];
    ls_wdata = corner_q[k_q];
    ls_raddr = '0;
    sm_in    = ls_rdata;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gmb_pkg::CFG_VERTEX_LIMIT: vlimit_d = cfg_data_i[6:0];
        gmb_pkg::CFG_INDEX_LIMIT:  ilimit_d = cfg_data_i;
        default:                   ilimit_d = ilimit_q;
      endcase
    end

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        rm_we    = 1'b1;
        rm_waddr = clr_q;
        clr_d    = clr_q + RAW'(1);
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          corner_d[0] = s_axis_tdata[15:0];
          corner_d[1] = s_axis_tdata[31:16];
          corner_d[2] = s_axis_tdata[47:32];
          finish_d    = (s_axis_tuser == gmb_pkg::ACT_FINISH);
          closed_d    = 1'b0;
          cvc_d       = '0;
          cic_d       = '0;
          added_d     = '0;
          k_d         = '0;
          for (int i = 0; i < 3; i++) begin
            loc_d[i]  = '0;
            newv_d[i] = '0;
          end
          if (s_axis_tuser == gmb_pkg::ACT_FINISH) begin
            if (ic_q != 9'd0) begin
              closed_d = 1'b1;
              cvc_d    = 7'(vc_q);
              cic_d    = ic_q;
              walk_d   = '0;
              pend_d   = 1'b0;
              state_d  = ST_WALK;
            end else begin
              mc_d    = '0;
              state_d = ST_DONE;
            end
          end else begin
            state_d = ST_RD_A;
          end
        end
      end
      ST_RD_A: begin
        sm_in    = corner_q[0];
        pos_d[0] = sm_slot;
        state_d  = ST_RD_B;
      end
      ST_RD_B: begin
        sm_in    = corner_q[1];
        pos_d[1] = sm_slot;
        rv_d[0]  = rm_rdata;
        state_d  = ST_RD_C;
      end
      ST_RD_C: begin
        sm_in    = corner_q[2];
        pos_d[2] = sm_slot;
        rv_d[1]  = rm_rdata;
        state_d  = ST_CHECK;
      end
      ST_CHECK: begin
        rv_d[2] = rm_rdata;
        if (vc_need > {1'b0, vlim} || ic_need > {1'b0, ilim}) begin
          closed_d = 1'b1;
          cvc_d    = 7'(vc_q);
          cic_d    = ic_q;
          walk_d   = '0;
          pend_d   = 1'b0;
          state_d  = ST_WALK;
        end else begin
          state_d = ST_APPEND;
        end
      end
      ST_WALK: begin
        // list read, then the remap clear in the cycle after it
        if (walk_q < vc_q) begin
          ls_raddr = walk_q[LAW-1:0];
          walk_d   = walk_q + VCW'(1);
          pend_d   = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          rm_we    = 1'b1;
          rm_waddr = sm_slot;
        end
        if (walk_q == vc_q && !pend_q) begin
          vc_d = '0;
          ic_d = '0;
          if (finish_q) begin
            mc_d    = '0;
            state_d = ST_DONE;
          end else begin
            mc_d    = mc_q + 16'd1;
            rv_d[0] = gmb_pkg::UNASSIGNED;
            rv_d[1] = gmb_pkg::UNASSIGNED;
            rv_d[2] = gmb_pkg::UNASSIGNED;
            state_d = ST_APPEND;
          end
        end
      end
      ST_APPEND: begin
        if (eff == gmb_pkg::UNASSIGNED && vc_q < VC_MAX) begin
          rm_we            = 1'b1;
          rm_wdata         = vc8;
          ls_we            = 1'b1;
          newv_d[added_q]  = corner_q[k_q];
          added_d          = added_q + 2'd1;
          vc_d             = vc_q + VCW'(1);
          fval_d[k_q]      = vc8;
          loc_d[k_q]       = vc8[5:0];
        end else begin
          fval_d[k_q] = eff;
          loc_d[k_q]  = eff[5:0];
        end
        if (k_q == 2'd2) begin
          ic_d    = ic_q + 9'd3;
          state_d = ST_DONE;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_user_d  = closed_q;
          m_data_d  = {4'b0, newv_q[2], newv_q[1], newv_q[0], added_q,
                       loc_q[2], loc_q[1], loc_q[0], mc_q, cic_q, cvc_q};
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      finish_q  <= 1'b0;
      corner_q  <= '{default: '0};
      pos_q     <= '{default: '0};
      rv_q      <= '{default: '0};
      fval_q    <= '{default: '0};
      k_q       <= '0;
      vc_q      <= '0;
      ic_q      <= '0;
      mc_q      <= '0;
      walk_q    <= '0;
      pend_q    <= 1'b0;
      closed_q  <= 1'b0;
      cvc_q     <= '0;
      cic_q     <= '0;
      loc_q     <= '{default: '0};
      added_q   <= '0;
      newv_q    <= '{default: '0};
      vlimit_q  <= gmb_pkg::VERTEX_LIMIT_RST;
      ilimit_q  <= gmb_pkg::INDEX_LIMIT_RST;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      finish_q  <= finish_d;
      corner_q  <= corner_d;
      pos_q     <= pos_d;
      rv_q      <= rv_d;
      fval_q    <= fval_d;
      k_q       <= k_d;
      vc_q      <= vc_d;
      ic_q      <= ic_d;
      mc_q      <= mc_d;
      walk_q    <= walk_d;
      pend_q    <= pend_d;
      closed_q  <= closed_d;
      cvc_q     <= cvc_d;
      cic_q     <= cic_d;
      loc_q     <= loc_d;
      added_q   <= added_d;
      newv_q    <= newv_d;
      vlimit_q  <= vlimit_d;
      ilimit_q  <= ilimit_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
      m_user_q  <= m_user_d;
    end
  end

endmodule
